[hdl/rsas_pkg.sv]
// Package for the search and attack sequencer: mode, motion and duty codes,
// the sequencer state and configuration structs and the mode entry function.
// No dependencies; used by every module in hdl.
`default_nettype none

package rsas_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_DETECTED = 3'd1,
        MODE_SEARCH   = 3'd2,
        MODE_ATTACK   = 3'd3,
        MODE_BORDER   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        MV_FWD   = 2'd0,
        MV_BACK  = 2'd1,
        MV_LEFT  = 2'd2,
        MV_RIGHT = 2'd3
    } motion_t;

    typedef enum logic [2:0] {
        DUTY_ROAM_FWD   = 3'd0,
        DUTY_ROAM_SPIN  = 3'd1,
        DUTY_DETECT_FWD = 3'd2,
        DUTY_SWEEP      = 3'd3,
        DUTY_PUSH       = 3'd4,
        DUTY_ATTACK_BCK = 3'd5,
        DUTY_BORDER     = 3'd6
    } duty_t;

    typedef enum logic [2:0] {
        REG_IDLE_FORWARD = 3'd0,
        REG_IDLE_TURN    = 3'd1,
        REG_SEARCH_TURN  = 3'd2,
        REG_SEARCH_MAX   = 3'd3,
        REG_ATTACK_PUSH  = 3'd4,
        REG_ATTACK_BACK  = 3'd5
    } reg_index_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [7:0]  LEFT_PERIODS = 8'd3;
    localparam logic [7:0]  PERIOD_MAX   = 8'd255;

    typedef struct packed {
        logic [15:0] idle_forward_ms;
        logic [15:0] idle_spin_ms;
        logic [15:0] search_turn_ms;
        logic [7:0]  search_max_periods;
        logic [15:0] attack_push_ms;
        logic [15:0] attack_retreat_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        idle_forward_ms:    16'd600,
        idle_spin_ms:       16'd400,
        search_turn_ms:     16'd200,
        search_max_periods: 8'd6,
        attack_push_ms:     16'd1000,
        attack_retreat_ms:  16'd400
    };

    typedef struct packed {
        mode_t       mode;
        logic [15:0] elapsed_ms;
        logic        idle_going_fwd;
        logic        idle_next_right;
        logic        search_left;
        logic [7:0]  search_count;
        logic        attack_push;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode:            MODE_IDLE,
        elapsed_ms:      16'd0,
        idle_going_fwd:  1'b1,
        idle_next_right: 1'b1,
        search_left:     1'b1,
        search_count:    8'd0,
        attack_push:     1'b1
    };

    typedef struct packed {
        mode_t   mode_now;
        duty_t   duty_select;
        motion_t motion;
        logic    drive_valid;
    } result_t;

    typedef struct packed {
        logic target_seen;
        logic edge_seen;
        logic audio_hold;
        logic start_button;
    } sensors_t;

    // Entering a mode restarts the timer and resets that mode's sub-phase.
    function automatic state_t enter_mode(state_t s, mode_t m);
        state_t r;
        r = s;
        r.mode = m;
        r.elapsed_ms = 16'd0;
        case (m)
            MODE_IDLE:
            begin
                r.idle_going_fwd = 1'b1;
            end
            MODE_SEARCH:
            begin
                r.search_left = 1'b1;
                r.search_count = 8'd0;
            end
            MODE_ATTACK:
            begin
                r.attack_push = 1'b1;
            end
            default:
            begin
                r.mode = m;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/robot_search_attack_sequencer_top.sv]
// Top level of the search and attack sequencer: input word register, sequencer
// state, result register and stream handshake. Uses rsas_pkg, rsas_cfg and rsas_core.
//
// Channel   Direction  Ports                          Word
// s_axis    in         s_tvalid s_tready s_tdata[7:0] one sensor tick
// m_axis    out        m_tvalid m_tready m_tdata[15:0] one drive command
// cfg       in         cfg_we cfg_index cfg_data      one register write
//
// A tick word is taken into the input register, evaluated against the
// sequencer state there and moves into the result register when that
// register is empty or being read, so one word is taken each cycle while
// m_tready does not hold the result.
// Writing the state with the result gives one word per clock when nothing stalls.
// A stall on m_tready holds the result and the input register; s_tready
// drops only when the input register is full and cannot move on.
// Reset loads the register defaults and the idle state, with both stages empty.
`default_nettype none

module robot_search_attack_sequencer_top #(
    parameter int unsigned TICK_STEP_MS = 20
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // target_seen, edge_seen, audio_hold, start_button, then zero fill.
    input  wire logic [7:0]                       s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // drive_valid, motion[1:0], duty_select[2:0], mode_now[2:0], then zero fill.
    output logic [15:0]                           m_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [rsas_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rsas_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rsas_pkg::cfg_t      cfg;
    rsas_pkg::sensors_t  in_word_reg;
    rsas_pkg::sensors_t  in_word_next;
    logic                in_valid_reg;
    logic                in_valid_next;
    rsas_pkg::state_t    state_reg;
    rsas_pkg::state_t    state_next;
    rsas_pkg::state_t    core_state;
    rsas_pkg::result_t   core_res;
    rsas_pkg::result_t   out_word_reg;
    rsas_pkg::result_t   out_word_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                advance;
    logic                s_take;

    rsas_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rsas_core #(
        .TICK_STEP_MS (TICK_STEP_MS)
    ) u_core (
        .sensors (in_word_reg),
        .cur     (state_reg),
        .cfg     (cfg),
        .nxt     (core_state),
        .res     (core_res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        in_word_next   = in_word_reg;
        in_valid_next  = in_valid_reg;
        state_next     = state_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            state_next     = core_state;
            out_word_next  = core_res;
            out_valid_next = 1'b1;
            in_valid_next  = 1'b0;
        end
        if (s_take)
        begin
            in_word_next  = {s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[3]};
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= rsas_pkg::STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_word_reg  <= in_word_next;
        out_word_reg <= out_word_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_word_reg.mode_now, out_word_reg.duty_select,
                       out_word_reg.motion, out_word_reg.drive_valid};

    // An idle result carries no motion and no duty selection.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_word_reg.drive_valid) |->
            (out_word_reg.motion == rsas_pkg::MV_FWD &&
             out_word_reg.duty_select == rsas_pkg::DUTY_ROAM_FWD))
        else $error("idle result carries a motion or duty code");

    // The border duty only ever goes with a right turn in border mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_word_reg.drive_valid &&
         out_word_reg.duty_select == rsas_pkg::DUTY_BORDER) |->
            (out_word_reg.motion == rsas_pkg::MV_RIGHT &&
             out_word_reg.mode_now == rsas_pkg::MODE_BORDER))
        else $error("border duty without border turn");

    // An audio override tick leaves the sequencer state untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_word_reg.audio_hold) |=> $stable(state_reg))
        else $error("state changed on audio override tick");

    // Back pressure reaches the input only through a full input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

[hdl/rsas_cfg.sv]
// Configuration register file of the search and attack sequencer.
// Depends on rsas_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module rsas_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [rsas_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rsas_pkg::CFG_DATA_W-1:0]     cfg_data,
    output rsas_pkg::cfg_t                           cfg
);

    rsas_pkg::cfg_t cfg_reg;
    rsas_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (rsas_pkg::reg_index_t'(cfg_index))
                rsas_pkg::REG_IDLE_FORWARD: cfg_next.idle_forward_ms = cfg_data;
                rsas_pkg::REG_IDLE_TURN:    cfg_next.idle_spin_ms = cfg_data;
                rsas_pkg::REG_SEARCH_TURN:  cfg_next.search_turn_ms = cfg_data;
                rsas_pkg::REG_SEARCH_MAX:   cfg_next.search_max_periods = cfg_data[7:0];
                rsas_pkg::REG_ATTACK_PUSH:  cfg_next.attack_push_ms = cfg_data;
                rsas_pkg::REG_ATTACK_BACK:  cfg_next.attack_retreat_ms = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= rsas_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[hdl/rsas_core.sv]
// Next-state and drive command logic of the search and attack sequencer for one tick.
// Purely combinational; depends on rsas_pkg for state, config and result types.
`default_nettype none

module rsas_core #(
    parameter int unsigned TICK_STEP_MS = 20
) (
    input  wire rsas_pkg::sensors_t sensors,
    input  wire rsas_pkg::state_t   cur,
    input  wire rsas_pkg::cfg_t     cfg,
    output rsas_pkg::state_t   nxt,
    output rsas_pkg::result_t  res
);

    localparam logic [16:0] STEP = 17'(TICK_STEP_MS);

    rsas_pkg::state_t w;
    logic             valid;
    rsas_pkg::motion_t motion;
    rsas_pkg::duty_t  duty;
    logic [7:0]       bumped;
    logic [16:0]      sum;

    always_comb
    begin
        w = cur;
        valid = 1'b0;
        motion = rsas_pkg::MV_FWD;
        duty = rsas_pkg::DUTY_ROAM_FWD;
        bumped = (cur.search_count < rsas_pkg::PERIOD_MAX) ? cur.search_count + 8'd1
                                                           : cur.search_count;
        sum = 17'd0;
        if (!sensors.audio_hold)
        begin
            if (sensors.edge_seen)
            begin
                if (cur.mode != rsas_pkg::MODE_BORDER)
                begin
                    w.mode = rsas_pkg::MODE_BORDER;
                    w.elapsed_ms = 16'd0;
                end
                valid = 1'b1;
                motion = rsas_pkg::MV_RIGHT;
                duty = rsas_pkg::DUTY_BORDER;
            end
            else
            begin
                if (cur.mode == rsas_pkg::MODE_BORDER)
                begin
                    w = rsas_pkg::enter_mode(cur, rsas_pkg::MODE_IDLE);
                end
                case (w.mode)
                    rsas_pkg::MODE_IDLE:
                    begin
                        if (sensors.target_seen)
                        begin
                            w = rsas_pkg::enter_mode(w, rsas_pkg::MODE_DETECTED);
                        end
                        else if (sensors.start_button)
                        begin
                            w = rsas_pkg::enter_mode(w, rsas_pkg::MODE_ATTACK);
                        end
                        else if (w.idle_going_fwd)
                        begin
                            valid = 1'b1;
                            motion = rsas_pkg::MV_FWD;
                            duty = rsas_pkg::DUTY_ROAM_FWD;
                            if (w.elapsed_ms >= cfg.idle_forward_ms)
                            begin
                                w.idle_going_fwd = 1'b0;
                                w.elapsed_ms = 16'd0;
                            end
                        end
                        else
                        begin
                            valid = 1'b1;
                            motion = w.idle_next_right ? rsas_pkg::MV_RIGHT
                                                       : rsas_pkg::MV_LEFT;
                            duty = rsas_pkg::DUTY_ROAM_SPIN;
                            if (w.elapsed_ms >= cfg.idle_spin_ms)
                            begin
                                w.idle_next_right = !w.idle_next_right;
                                w.idle_going_fwd = 1'b1;
                                w.elapsed_ms = 16'd0;
                            end
                        end
                    end
                    rsas_pkg::MODE_DETECTED:
                    begin
                        if (sensors.start_button)
                        begin
                            w = rsas_pkg::enter_mode(w, rsas_pkg::MODE_ATTACK);
                        end
                        else if (!sensors.target_seen)
                        begin
                            w = rsas_pkg::enter_mode(w, rsas_pkg::MODE_SEARCH);
                        end
                        else
                        begin
                            valid = 1'b1;
                            motion = rsas_pkg::MV_FWD;
                            duty = rsas_pkg::DUTY_DETECT_FWD;
                        end
                    end
                    rsas_pkg::MODE_SEARCH:
                    begin
                        if (sensors.target_seen)
                        begin
                            w = rsas_pkg::enter_mode(w, rsas_pkg::MODE_DETECTED);
                        end
                        else if (sensors.start_button)
                        begin
                            w = rsas_pkg::enter_mode(w, rsas_pkg::MODE_ATTACK);
                        end
                        else
                        begin
                            valid = 1'b1;
                            motion = w.search_left ? rsas_pkg::MV_LEFT : rsas_pkg::MV_RIGHT;
                            duty = rsas_pkg::DUTY_SWEEP;
                            if (w.elapsed_ms >= cfg.search_turn_ms)
                            begin
                                w.search_count = bumped;
                                w.elapsed_ms = 16'd0;
                                if (w.search_left)
                                begin
                                    if (bumped >= rsas_pkg::LEFT_PERIODS)
                                    begin
                                        w.search_left = 1'b0;
                                        w.search_count = 8'd0;
                                    end
                                end
                                else if (bumped >= cfg.search_max_periods)
                                begin
                                    w = rsas_pkg::enter_mode(w, rsas_pkg::MODE_IDLE);
                                end
                            end
                        end
                    end
                    rsas_pkg::MODE_ATTACK:
                    begin
                        valid = 1'b1;
                        if (w.attack_push)
                        begin
                            motion = rsas_pkg::MV_FWD;
                            duty = rsas_pkg::DUTY_PUSH;
                            if (w.elapsed_ms >= cfg.attack_push_ms)
                            begin
                                w.attack_push = 1'b0;
                                w.elapsed_ms = 16'd0;
                            end
                        end
                        else
                        begin
                            motion = rsas_pkg::MV_BACK;
                            duty = rsas_pkg::DUTY_ATTACK_BCK;
                            if (w.elapsed_ms >= cfg.attack_retreat_ms)
                            begin
                                w = rsas_pkg::enter_mode(w, sensors.target_seen
                                                            ? rsas_pkg::MODE_DETECTED
                                                            : rsas_pkg::MODE_IDLE);
                            end
                        end
                    end
                    default:
                    begin
                        w = rsas_pkg::enter_mode(w, rsas_pkg::MODE_IDLE);
                    end
                endcase
            end
            sum = {1'b0, w.elapsed_ms} + STEP;
            w.elapsed_ms = sum[16] ? 16'hFFFF : sum[15:0];
        end
    end

    assign nxt = w;
    assign res.drive_valid = valid;
    assign res.motion = motion;
    assign res.duty_select = duty;
    assign res.mode_now = w.mode;

endmodule

`default_nettype wire

[tb/robot_search_attack_sequencer_top_tb.sv]
`timescale 1ns / 1ps
// Testbench for robot_search_attack_sequencer_top: streams sensor tick words,
// predicts every drive command word in a scoreboard and checks it field by field.
// Depends on rsas_pkg and the RTL in hdl; needs nothing else.

module robot_search_attack_sequencer_top_tb;

    localparam int TICK_MS = 20;
    localparam int STALL_LIMIT = 1000;

    class drive_scoreboard;
        rsas_pkg::cfg_t      cfg;
        rsas_pkg::mode_t     mode;
        logic [15:0]         elapsed_ms;
        bit                  going_fwd;
        bit                  next_right;
        bit                  search_left;
        bit                  push_phase;
        logic [7:0]          periods;
        rsas_pkg::result_t   due_cmds[$];
        int                  errors;

        function new();
            cfg = rsas_pkg::CFG_RESET;
            mode = rsas_pkg::MODE_IDLE;
            elapsed_ms = '0;
            going_fwd = 1'b1;
            next_right = 1'b1;
            search_left = 1'b1;
            push_phase = 1'b1;
            periods = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                rsas_pkg::REG_IDLE_FORWARD: cfg.idle_forward_ms = v;
                rsas_pkg::REG_IDLE_TURN:    cfg.idle_spin_ms = v;
                rsas_pkg::REG_SEARCH_TURN:  cfg.search_turn_ms = v;
                rsas_pkg::REG_SEARCH_MAX:   cfg.search_max_periods = v[7:0];
                rsas_pkg::REG_ATTACK_PUSH:  cfg.attack_push_ms = v;
                rsas_pkg::REG_ATTACK_BACK:  cfg.attack_retreat_ms = v;
                default:                    ;
            endcase
        endfunction

        function void switch_mode(rsas_pkg::mode_t m);
            mode = m;
            elapsed_ms = '0;
            if (m == rsas_pkg::MODE_IDLE)
                going_fwd = 1'b1;
            else if (m == rsas_pkg::MODE_SEARCH)
            begin
                search_left = 1'b1;
                periods = '0;
            end
            else if (m == rsas_pkg::MODE_ATTACK)
                push_phase = 1'b1;
        endfunction

        function void bump_periods();
            if (periods < rsas_pkg::PERIOD_MAX)
                periods++;
            elapsed_ms = '0;
        endfunction

        function void note_tick(rsas_pkg::sensors_t t);
            rsas_pkg::result_t r;
            logic [16:0]       sum;
            logic [7:0]        limit;
            r.drive_valid = 1'b0;
            r.motion = rsas_pkg::MV_FWD;
            r.duty_select = rsas_pkg::DUTY_ROAM_FWD;
            if (!t.audio_hold)
            begin
                if (t.edge_seen)
                begin
                    if (mode != rsas_pkg::MODE_BORDER)
                    begin
                        mode = rsas_pkg::MODE_BORDER;
                        elapsed_ms = '0;
                    end
                    r = '{mode_now: mode, duty_select: rsas_pkg::DUTY_BORDER,
                          motion: rsas_pkg::MV_RIGHT, drive_valid: 1'b1};
                end
                else
                begin
                    if (mode == rsas_pkg::MODE_BORDER)
                        switch_mode(rsas_pkg::MODE_IDLE);
                    case (mode)
                        rsas_pkg::MODE_IDLE:
                        begin
                            if (t.target_seen)
                                switch_mode(rsas_pkg::MODE_DETECTED);
                            else if (t.start_button)
                                switch_mode(rsas_pkg::MODE_ATTACK);
                            else if (going_fwd)
                            begin
                                r.drive_valid = 1'b1;
                                r.motion = rsas_pkg::MV_FWD;
                                r.duty_select = rsas_pkg::DUTY_ROAM_FWD;
                                if (elapsed_ms >= cfg.idle_forward_ms)
                                begin
                                    going_fwd = 1'b0;
                                    elapsed_ms = '0;
                                end
                            end
                            else
                            begin
                                r.drive_valid = 1'b1;
                                r.motion = next_right ? rsas_pkg::MV_RIGHT : rsas_pkg::MV_LEFT;
                                r.duty_select = rsas_pkg::DUTY_ROAM_SPIN;
                                if (elapsed_ms >= cfg.idle_spin_ms)
                                begin
                                    next_right = !next_right;
                                    going_fwd = 1'b1;
                                    elapsed_ms = '0;
                                end
                            end
                        end
                        rsas_pkg::MODE_DETECTED:
                        begin
                            if (t.start_button)
                                switch_mode(rsas_pkg::MODE_ATTACK);
                            else if (!t.target_seen)
                                switch_mode(rsas_pkg::MODE_SEARCH);
                            else
                            begin
                                r.drive_valid = 1'b1;
                                r.motion = rsas_pkg::MV_FWD;
                                r.duty_select = rsas_pkg::DUTY_DETECT_FWD;
                            end
                        end
                        rsas_pkg::MODE_SEARCH:
                        begin
                            if (t.target_seen)
                                switch_mode(rsas_pkg::MODE_DETECTED);
                            else if (t.start_button)
                                switch_mode(rsas_pkg::MODE_ATTACK);
                            else
                            begin
                                r.drive_valid = 1'b1;
                                r.motion = search_left ? rsas_pkg::MV_LEFT : rsas_pkg::MV_RIGHT;
                                r.duty_select = rsas_pkg::DUTY_SWEEP;
                                if (elapsed_ms >= cfg.search_turn_ms)
                                begin
                                    bump_periods();
                                    limit = (cfg.search_max_periods == 8'd0) ?
                                            8'd1 : cfg.search_max_periods;
                                    if (search_left && periods >= rsas_pkg::LEFT_PERIODS)
                                    begin
                                        search_left = 1'b0;
                                        periods = '0;
                                    end
                                    else if (!search_left && periods >= limit)
                                        switch_mode(rsas_pkg::MODE_IDLE);
                                end
                            end
                        end
                        rsas_pkg::MODE_ATTACK:
                        begin
                            r.drive_valid = 1'b1;
                            if (push_phase)
                            begin
                                r.motion = rsas_pkg::MV_FWD;
                                r.duty_select = rsas_pkg::DUTY_PUSH;
                                if (elapsed_ms >= cfg.attack_push_ms)
                                begin
                                    push_phase = 1'b0;
                                    elapsed_ms = '0;
                                end
                            end
                            else
                            begin
                                r.motion = rsas_pkg::MV_BACK;
                                r.duty_select = rsas_pkg::DUTY_ATTACK_BCK;
                                if (elapsed_ms >= cfg.attack_retreat_ms)
                                    switch_mode(t.target_seen ? rsas_pkg::MODE_DETECTED
                                                              : rsas_pkg::MODE_IDLE);
                            end
                        end
                        default: switch_mode(rsas_pkg::MODE_IDLE);
                    endcase
                end
                sum = {1'b0, elapsed_ms} + 17'(TICK_MS);
                elapsed_ms = (sum > 17'd65535) ? 16'hFFFF : sum[15:0];
            end
            r.mode_now = mode;
            due_cmds.push_back(r);
        endfunction

        function void check_field(string what, logic [2:0] want, logic [2:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            end
        endfunction

        function void check_cmd(logic [15:0] word);
            rsas_pkg::result_t want;
            rsas_pkg::result_t got;
            got = rsas_pkg::result_t'(word[8:0]);
            if (due_cmds.size() == 0)
            begin
                errors++;
                $display("%0t: drive word %h arrived with none expected", $time, word);
                return;
            end
            want = due_cmds.pop_front();
            check_field("drive_valid", 3'(want.drive_valid), 3'(got.drive_valid));
            check_field("motion", 3'(want.motion), 3'(got.motion));
            check_field("duty_select", want.duty_select, got.duty_select);
            check_field("mode_now", want.mode_now, got.mode_now);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    drive_scoreboard sb = new();
    bit gaps_on = 1'b1;
    bit tgt_level = 1'b0;

    // Opening sequence, bits from high to low: target, edge, audio, button.
    logic [3:0] opening_ticks [22] = '{
        4'b0000, 4'b1111, 4'b0100, 4'b1101, 4'b0000, 4'b0010, 4'b1000, 4'b1000,
        4'b0000, 4'b0000, 4'b1000, 4'b0000, 4'b0001, 4'b0000, 4'b0100, 4'b0000,
        4'b0001, 4'b1001, 4'b0000, 4'b0100, 4'b1000, 4'b1001
    };

    robot_search_attack_sequencer_top #(
        .TICK_STEP_MS(TICK_MS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsas_pkg::sensors_t next_tick(int unsigned rate);
        rsas_pkg::sensors_t t;
        if ($urandom_range(0, 1999) < rate)
            return rsas_pkg::sensors_t'(4'($urandom_range(0, 15)));
        if ($urandom_range(0, 999) < rate)
            tgt_level = !tgt_level;
        t.target_seen = tgt_level;
        t.edge_seen = ($urandom_range(0, 1999) < rate);
        t.audio_hold = ($urandom_range(0, 1999) < rate);
        t.start_button = ($urandom_range(0, 1999) < rate);
        return t;
    endfunction

    task automatic send_tick(input rsas_pkg::sensors_t t);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, t.start_button, t.audio_hold, t.edge_seen, t.target_seen};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_tick(t);
    endtask

    task automatic run_random(input int unsigned count, input int unsigned rate);
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            send_tick(next_tick(rate));
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.due_cmds.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_regs(input rsas_pkg::cfg_t c, input logic [7:0] max_hi);
        logic [15:0] d;
        for (int i = 0; i < 8; i++)
        begin
            case (rsas_pkg::reg_index_t'(i))
                rsas_pkg::REG_IDLE_FORWARD: d = c.idle_forward_ms;
                rsas_pkg::REG_IDLE_TURN:    d = c.idle_spin_ms;
                rsas_pkg::REG_SEARCH_TURN:  d = c.search_turn_ms;
                rsas_pkg::REG_SEARCH_MAX:   d = {max_hi, c.search_max_periods};
                rsas_pkg::REG_ATTACK_PUSH:  d = c.attack_push_ms;
                rsas_pkg::REG_ATTACK_BACK:  d = c.attack_retreat_ms;
                default:                    d = 16'($urandom);
            endcase
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= d;
            @(posedge clk);
            sb.write_reg(3'(i), d);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned hold;
        int unsigned seen;
        hold = 0;
        seen = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                sb.check_cmd(m_tdata);
                seen++;
                if (seen == 150 || seen == 1500)
                    hold = 64;
                else
                    hold = gaps_on ? $urandom_range(0, 3) : 0;
            end
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rsas_pkg::cfg_t c;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_regs(rsas_pkg::CFG_RESET, 8'h00);
        foreach (opening_ticks[i])
            send_tick(rsas_pkg::sensors_t'(opening_ticks[i]));
        run_random(300, 20);
        settle();

        // All timers at zero and a period limit of zero, which acts as one.
        c = '0;
        program_regs(c, 8'h00);
        run_random(250, 150);
        settle();

        // Short timers; the upper byte of the period limit must be dropped.
        c = '{idle_forward_ms: 16'd40, idle_spin_ms: 16'd20, search_turn_ms: 16'd40,
              search_max_periods: 8'd2, attack_push_ms: 16'd60, attack_retreat_ms: 16'd40};
        program_regs(c, 8'hA5);
        run_random(300, 80);
        settle();

        c.idle_forward_ms = 16'($urandom_range(0, 200));
        c.idle_spin_ms = 16'($urandom_range(0, 200));
        c.search_turn_ms = 16'($urandom_range(0, 200));
        c.search_max_periods = 8'($urandom_range(1, 8));
        c.attack_push_ms = 16'($urandom_range(0, 200));
        c.attack_retreat_ms = 16'($urandom_range(0, 200));
        program_regs(c, 8'($urandom));
        run_random(250, 60);
        settle();

        // Longest fast search: one tick per period up to the counter's top.
        c = '{idle_forward_ms: 16'd60, idle_spin_ms: 16'd40, search_turn_ms: 16'd0,
              search_max_periods: 8'hFF, attack_push_ms: 16'd20, attack_retreat_ms: 16'd20};
        program_regs(c, 8'h00);
        tgt_level = 1'b0;
        send_tick(rsas_pkg::sensors_t'(4'b1000));
        run_random(350, 3);
        settle();

        // Largest timers: the attack push outlasts the whole stretch.
        c = '{idle_forward_ms: 16'hFFFF, idle_spin_ms: 16'hFFFF, search_turn_ms: 16'hFFFF,
              search_max_periods: 8'hFF, attack_push_ms: 16'hFFFF,
              attack_retreat_ms: 16'hFFFF};
        program_regs(c, 8'hFF);
        send_tick(rsas_pkg::sensors_t'(4'b0001));
        for (int n = 0; n < 200; n++)
        begin
            if (n % 100 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            send_tick('0);
        end
        run_random(150, 40);
        settle();

        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.due_cmds.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/rsas_pkg.sv
hdl/rsas_cfg.sv
hdl/rsas_core.sv
hdl/robot_search_attack_sequencer_top.sv
tb/robot_search_attack_sequencer_top_tb.sv
